// File: rtl/core/etp_pkg.sv
// Shared types, register codes and defaults for the escape-time pixel unit.
package etp_pkg;

    localparam int FRAC_BITS_DEF   = 28;
    localparam int COORD_WIDTH_DEF = 12;
    localparam int ITER_WIDTH_DEF  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIGIT_W    = 16;
    localparam int BLUE_STEPS = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZOOM       = 3'd0,
        REG_MAX_ITER   = 3'd1,
        REG_COLOR_MODE = 3'd2,
        REG_ORIGIN_RE  = 3'd3,
        REG_ORIGIN_IM  = 3'd4
    } t_reg_idx;

    localparam logic [15:0]        ZOOM_RST      = 16'd2500;
    localparam logic [15:0]        MAX_ITER_RST  = 16'd500;
    localparam logic               COLOR_RST     = 1'b1;
    localparam logic signed [31:0] ORIGIN_RE_RST = -32'sd563714458;
    localparam logic signed [31:0] ORIGIN_IM_RST = -32'sd322122547;

    typedef struct packed {
        logic [15:0]        zoom;
        logic [15:0]        max_iter;
        logic               color_mode;
        logic signed [31:0] origin_re;
        logic signed [31:0] origin_im;
    } t_cfg;

    typedef struct packed {
        logic load_in;
        logic div_step;
        logic map;
        logic sum;
        logic upd;
        logic mul_load;
        logic mul_step;
        logic rnd;
        logic blue_load;
        logic blue_step;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic escaped;
        logic at_limit;
    } t_dp_status;

endpackage

// File: rtl/core/etp_cfg.sv
// Configuration register file written through the configuration channel.
module etp_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [etp_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [etp_pkg::CFG_DATA_W-1:0] i_data,
    output etp_pkg::t_cfg                 o_cfg
);

    etp_pkg::t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zoom       <= etp_pkg::ZOOM_RST;
            r_cfg.max_iter   <= etp_pkg::MAX_ITER_RST;
            r_cfg.color_mode <= etp_pkg::COLOR_RST;
            r_cfg.origin_re  <= etp_pkg::ORIGIN_RE_RST;
            r_cfg.origin_im  <= etp_pkg::ORIGIN_IM_RST;
        end else if (i_valid) begin
            case (etp_pkg::t_reg_idx'(i_index))
                etp_pkg::REG_ZOOM:       r_cfg.zoom       <= i_data[15:0];
                etp_pkg::REG_MAX_ITER:   r_cfg.max_iter   <= i_data[15:0];
                etp_pkg::REG_COLOR_MODE: r_cfg.color_mode <= i_data[0];
                etp_pkg::REG_ORIGIN_RE:  r_cfg.origin_re  <= i_data;
                etp_pkg::REG_ORIGIN_IM:  r_cfg.origin_im  <= i_data;
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/etp_mul.sv
// Digit-serial signed fixed-point multiplier with floor rounding and saturation.
module etp_mul #(
    parameter int FRAC_BITS = etp_pkg::FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic                 i_step,
    input  logic [FRAC_BITS+3:0] i_a,
    input  logic [FRAC_BITS+3:0] i_b,
    output logic [FRAC_BITS+3:0] o_q
);

    localparam int W  = FRAC_BITS + 4;
    localparam int DW = etp_pkg::DIGIT_W;
    localparam int ND = (W + DW - 1) / DW;
    localparam int BW = ND * DW;
    localparam int AW = W + BW;
    localparam int MW = AW - FRAC_BITS + 1;
    localparam logic [MW-1:0] QMAXU = MW'({(W-1){1'b1}});
    localparam logic [W-1:0]  QMAX  = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  QMIN  = {1'b1, {(W-1){1'b0}}};

    logic          r_neg;
    logic [W-1:0]  r_ma;
    logic [BW-1:0] r_mb;
    logic [AW-1:0] r_acc;

    logic [W-1:0]    ma;
    logic [W-1:0]    mb;
    logic [W+DW-1:0] pp;
    logic            rest;
    logic [MW-1:0]   mag;

    assign ma = i_a[W-1] ? (~i_a + W'(1)) : i_a;
    assign mb = i_b[W-1] ? (~i_b + W'(1)) : i_b;
    assign pp = (W+DW)'(r_ma) * (W+DW)'(r_mb[BW-1 -: DW]);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_ma  <= ma;
            r_mb  <= BW'(mb);
            r_acc <= '0;
        end else if (i_step) begin
            r_acc <= (r_acc << DW) + AW'(pp);
            r_mb  <= r_mb << DW;
        end
    end

    assign rest = |r_acc[FRAC_BITS-1:0];
    assign mag  = {1'b0, r_acc[AW-1:FRAC_BITS]} + MW'(r_neg & rest);

    always_comb begin
        if (mag > QMAXU) begin
            o_q = r_neg ? QMIN : QMAX;
        end else if (r_neg) begin
            o_q = ~mag[W-1:0] + W'(1);
        end else begin
            o_q = mag[W-1:0];
        end
    end

endmodule

// File: rtl/core/etp_ctrl.sv
// Sequencer for coordinate mapping, the escape iteration and the blue scaling.
module etp_ctrl #(
    parameter int FRAC_BITS   = etp_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = etp_pkg::COORD_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output etp_pkg::t_dp_cmd     o_cmd,
    input  etp_pkg::t_dp_status  i_sts
);

    localparam int W         = FRAC_BITS + 4;
    localparam int ND        = (W + etp_pkg::DIGIT_W - 1) / etp_pkg::DIGIT_W;
    localparam int DIV_STEPS = COORD_WIDTH + FRAC_BITS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_MAP, S_SUM, S_UPD, S_MLD, S_MUL, S_RND, S_BLD, S_BDIV, S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             finish;
    logic             out_free;

    assign finish      = !i_sts.count_zero && (i_sts.escaped || i_sts.at_limit);
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = (r_state == S_IDLE) && i_in_valid;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.map       = (r_state == S_MAP);
        o_cmd.sum       = (r_state == S_SUM);
        o_cmd.upd       = (r_state == S_UPD) && !finish;
        o_cmd.mul_load  = (r_state == S_MLD);
        o_cmd.mul_step  = (r_state == S_MUL);
        o_cmd.rnd       = (r_state == S_RND);
        o_cmd.blue_load = (r_state == S_BLD);
        o_cmd.blue_step = (r_state == S_BDIV);
        o_cmd.out_load  = (r_state == S_OUT) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_cnt   <= CNT_W'(DIV_STEPS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_MAP;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_MAP: r_state <= S_SUM;
                S_SUM: r_state <= S_UPD;
                S_UPD: begin
                    r_state <= finish ? S_BLD : S_MLD;
                end
                S_MLD: begin
                    r_cnt   <= CNT_W'(ND - 1);
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    if (r_cnt == '0) begin
                        r_state <= S_RND;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_RND: r_state <= S_SUM;
                S_BLD: begin
                    r_cnt   <= CNT_W'(etp_pkg::BLUE_STEPS - 1);
                    r_state <= S_BDIV;
                end
                S_BDIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: rtl/core/etp_dp.sv
// Datapath: coordinate dividers, complex iteration registers, blue scaler, result register.
module etp_dp #(
    parameter int FRAC_BITS   = etp_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = etp_pkg::COORD_WIDTH_DEF,
    parameter int ITER_WIDTH  = etp_pkg::ITER_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  etp_pkg::t_cfg          i_cfg,
    input  etp_pkg::t_dp_cmd       i_cmd,
    output etp_pkg::t_dp_status    o_sts,
    input  logic [COORD_WIDTH-1:0] i_pixel_x,
    input  logic [COORD_WIDTH-1:0] i_pixel_y,
    output logic [COORD_WIDTH-1:0] o_out_x,
    output logic [COORD_WIDTH-1:0] o_out_y,
    output logic [ITER_WIDTH-1:0]  o_iteration_count,
    output logic                   o_write_pixel,
    output logic [7:0]             o_blue_level,
    output logic                   o_is_white
);

    localparam int W      = FRAC_BITS + 4;
    localparam int QW     = COORD_WIDTH + FRAC_BITS;
    localparam int SH_UP  = (FRAC_BITS >= 28) ? FRAC_BITS - 28 : 0;
    localparam int SH_DN  = (FRAC_BITS < 28) ? 28 - FRAC_BITS : 0;
    localparam int IW     = ITER_WIDTH;
    localparam int BS     = etp_pkg::BLUE_STEPS;

    localparam logic signed [W+1:0] QMAX_X = {3'b000, {(W-1){1'b1}}};
    localparam logic signed [W+1:0] QMIN_X = {3'b111, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] QMAX   = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] QMIN   = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] FOUR   = {2'b01, {(W-2){1'b0}}};

    function automatic logic signed [W-1:0] f_sat(input logic signed [W+1:0] s);
        if (s > QMAX_X) begin
            return QMAX;
        end else if (s < QMIN_X) begin
            return QMIN;
        end
        return s[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] f_add(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        return f_sat($signed({{2{a[W-1]}}, a}) + $signed({{2{b[W-1]}}, b}));
    endfunction

    function automatic logic signed [W-1:0] f_sub(input logic signed [W-1:0] a,
                                                  input logic signed [W-1:0] b);
        return f_sat($signed({{2{a[W-1]}}, a}) - $signed({{2{b[W-1]}}, b}));
    endfunction

    function automatic logic [16:0] f_trial(input logic [15:0] rem, input logic dbit,
                                            input logic [15:0] dvs);
        logic [16:0] r2;
        logic        ge;
        r2 = {rem, dbit};
        ge = r2 >= {1'b0, dvs};
        if (ge) begin
            r2 = r2 - {1'b0, dvs};
        end
        return {ge, r2[15:0]};
    endfunction

    function automatic logic signed [W-1:0] f_map(input logic [QW-1:0] q,
                                                  input logic signed [W-1:0] o);
        if (|q[QW-1:W]) begin
            return QMAX;
        end
        return f_sat($signed({{2{o[W-1]}}, o}) + $signed({2'b00, q[W-1:0]}));
    endfunction

    logic [COORD_WIDTH-1:0] r_px, r_py, r_dx, r_dy;
    logic [15:0]            r_rx, r_ry;
    logic [QW-1:0]          r_qx, r_qy;

    logic signed [W-1:0] r_cr, r_ci, r_zr, r_zi, r_rr, r_ii, r_xx, r_s, r_d, r_c2;
    logic [IW-1:0]       r_cnt;

    logic [IW-1:0] r_brem;
    logic [BS-1:0] r_bn, r_bq;

    logic [COORD_WIDTH-1:0] r_o_x, r_o_y;
    logic [IW-1:0]          r_o_cnt;
    logic                   r_o_write, r_o_white;
    logic [7:0]             r_o_blue;

    logic [15:0]         zoom_eff;
    logic [IW-1:0]       lim_raw, lim;
    logic signed [63:0]  ore_ext, oim_ext, ore_sh, oim_sh;
    logic signed [W-1:0] ore_sc, oim_sc;
    logic [16:0]         tx, ty;
    logic [W-1:0]        q_rr, q_ii, q_xx;
    logic [IW+7:0]       bn_full;
    logic [IW:0]         brem2;
    logic                bge;
    logic                in_set, paint;

    assign zoom_eff = (i_cfg.zoom == '0) ? 16'd1 : i_cfg.zoom;
    assign lim_raw  = IW'(i_cfg.max_iter);
    assign lim      = (lim_raw == '0) ? IW'(1) : lim_raw;

    assign ore_ext = $signed({{32{i_cfg.origin_re[31]}}, i_cfg.origin_re});
    assign oim_ext = $signed({{32{i_cfg.origin_im[31]}}, i_cfg.origin_im});
    assign ore_sh  = (ore_ext <<< SH_UP) >>> SH_DN;
    assign oim_sh  = (oim_ext <<< SH_UP) >>> SH_DN;
    assign ore_sc  = ore_sh[W-1:0];
    assign oim_sc  = oim_sh[W-1:0];

    assign tx = f_trial(r_rx, r_dx[COORD_WIDTH-1], zoom_eff);
    assign ty = f_trial(r_ry, r_dy[COORD_WIDTH-1], zoom_eff);

    etp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_rr (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul_load),
        .i_step (i_cmd.mul_step),
        .i_a    (r_zr),
        .i_b    (r_zr),
        .o_q    (q_rr)
    );

    etp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_ii (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul_load),
        .i_step (i_cmd.mul_step),
        .i_a    (r_zi),
        .i_b    (r_zi),
        .o_q    (q_ii)
    );

    etp_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_xx (
        .i_clk  (i_clk),
        .i_load (i_cmd.mul_load),
        .i_step (i_cmd.mul_step),
        .i_a    (r_zi),
        .i_b    (r_zr),
        .o_q    (q_xx)
    );

    assign bn_full = {r_cnt, 8'b0} - {8'b0, r_cnt};
    assign brem2   = {r_brem, r_bn[BS-1]};
    assign bge     = brem2 >= {1'b0, lim};

    assign in_set = (r_cnt == lim);
    assign paint  = i_cfg.color_mode ? !in_set : in_set;

    assign o_sts.count_zero = (r_cnt == '0);
    assign o_sts.escaped    = (r_s >= FOUR);
    assign o_sts.at_limit   = in_set;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_px <= i_pixel_x;
            r_py <= i_pixel_y;
            r_dx <= i_pixel_x;
            r_dy <= i_pixel_y;
            r_rx <= '0;
            r_ry <= '0;
            r_qx <= '0;
            r_qy <= '0;
        end else if (i_cmd.div_step) begin
            r_dx <= r_dx << 1;
            r_dy <= r_dy << 1;
            r_rx <= tx[15:0];
            r_ry <= ty[15:0];
            r_qx <= {r_qx[QW-2:0], tx[16]};
            r_qy <= {r_qy[QW-2:0], ty[16]};
        end

        if (i_cmd.map) begin
            r_cr  <= f_map(r_qx, ore_sc);
            r_ci  <= f_map(r_qy, oim_sc);
            r_zr  <= '0;
            r_zi  <= '0;
            r_rr  <= '0;
            r_ii  <= '0;
            r_xx  <= '0;
            r_cnt <= '0;
        end else if (i_cmd.upd) begin
            r_zr  <= f_add(r_d, r_cr);
            r_zi  <= f_add(r_c2, r_ci);
            r_cnt <= r_cnt + 1'b1;
        end else if (i_cmd.rnd) begin
            r_rr <= q_rr;
            r_ii <= q_ii;
            r_xx <= q_xx;
        end

        if (i_cmd.sum) begin
            r_s  <= f_add(r_rr, r_ii);
            r_d  <= f_sub(r_rr, r_ii);
            r_c2 <= f_add(r_xx, r_xx);
        end

        if (i_cmd.blue_load) begin
            r_brem <= bn_full[IW+7:8];
            r_bn   <= bn_full[7:0];
            r_bq   <= '0;
        end else if (i_cmd.blue_step) begin
            r_brem <= bge ? brem2[IW-1:0] - lim : brem2[IW-1:0];
            r_bn   <= r_bn << 1;
            r_bq   <= {r_bq[BS-2:0], bge};
        end

        if (i_cmd.out_load) begin
            r_o_x     <= r_px;
            r_o_y     <= r_py;
            r_o_cnt   <= r_cnt;
            r_o_write <= paint;
            r_o_white <= !i_cfg.color_mode && paint;
            r_o_blue  <= (i_cfg.color_mode && paint) ? r_bq : 8'd0;
        end
    end

    assign o_out_x           = r_o_x;
    assign o_out_y           = r_o_y;
    assign o_iteration_count = r_o_cnt;
    assign o_write_pixel     = r_o_write;
    assign o_blue_level      = r_o_blue;
    assign o_is_white        = r_o_white;

endmodule

// File: rtl/core/mandelbrot_escape_time_pixel_unit.sv
// Top level of the escape-time pixel unit: config registers, sequencer and datapath.
//
//  channel   dir  handshake                        payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready  tdata: pixel_x, pixel_y
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready  tdata: out_x, out_y, count, blue
//                                                  tuser: write_pixel, is_white
//  cfg       in   i_cfg_valid/o_cfg_ready          i_cfg_index, i_cfg_data
//
// The iteration loop runs through three 16-bit-digit multipliers, each with
// D = ceil((FRAC_BITS + 4) / 16) multiplier digits (D = 2 at defaults).
// One pixel is in work at a time; a new transaction is taken while the result waits.
// A stalled output holds the result register; the unit then waits before writing the next.
// Synchronous active-low reset clears the sequencer and loads register defaults.
module mandelbrot_escape_time_pixel_unit #(
    parameter int FRAC_BITS   = etp_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = etp_pkg::COORD_WIDTH_DEF,
    parameter int ITER_WIDTH  = etp_pkg::ITER_WIDTH_DEF,
    localparam int IN_TDATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8,
    localparam int OUT_BITS    = 2 * COORD_WIDTH + ITER_WIDTH + 8,
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    // pixel_x, pixel_y
    input  logic [IN_TDATA_W-1:0]          i_s_axis_tdata,
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    // out_x, out_y, iteration_count, blue_level
    output logic [OUT_TDATA_W-1:0]         o_m_axis_tdata,
    // write_pixel, is_white
    output logic [1:0]                     o_m_axis_tuser,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [etp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [etp_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    etp_pkg::t_cfg       cfg;
    etp_pkg::t_dp_cmd    cmd;
    etp_pkg::t_dp_status sts;

    logic [COORD_WIDTH-1:0] out_x, out_y;
    logic [ITER_WIDTH-1:0]  out_cnt;
    logic                   out_write, out_white;
    logic [7:0]             out_blue;

    etp_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    etp_ctrl #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    etp_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH),
        .ITER_WIDTH  (ITER_WIDTH)
    ) u_dp (
        .i_clk             (i_clk),
        .i_cfg             (cfg),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_pixel_x         (i_s_axis_tdata[COORD_WIDTH-1:0]),
        .i_pixel_y         (i_s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
        .o_out_x           (out_x),
        .o_out_y           (out_y),
        .o_iteration_count (out_cnt),
        .o_write_pixel     (out_write),
        .o_blue_level      (out_blue),
        .o_is_white        (out_white)
    );

    assign o_m_axis_tdata = OUT_TDATA_W'({out_blue, out_cnt, out_y, out_x});
    assign o_m_axis_tuser = {out_white, out_write};

endmodule
